/* sv/vmt_pkg.sv */
`default_nettype none

package vmt_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int SUM_W   = 66;                  // exact Q34.32 column sum
  localparam int MAG_W   = SUM_W - 1;           // magnitude of a column sum
  localparam int NUM_W   = MAG_W + FRAC_W;      // dividend, sum scaled by 2^16
  localparam int QBITS   = 32;                  // quotient bits produced
  localparam int REM_W   = MAG_W + QBITS;       // compare width for the divider
  localparam int NREG    = 8;
  localparam int CFG_W   = 64;
  localparam int IDX_W   = 3;
  localparam int NLANE   = 3;

  localparam logic OP_POINT = 1'b0;
  localparam logic OP_DIR   = 1'b1;

  localparam logic [COORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

  // Identity matrix
  localparam logic [CFG_W-1:0] M_RESET [NREG] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

  typedef logic signed [SUM_W-1:0] vmt_sum_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } vmt_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               w_zero;
  } vmt_out_t;

  typedef struct packed {
    logic     is_dir;
    logic     w_zero;
    vmt_sum_t sx;
    vmt_sum_t sy;
    vmt_sum_t sz;
    vmt_sum_t sw;
  } vmt_mid_t;

endpackage

`default_nettype wire

/* sv/vmt_fifo.sv */
`default_nettype none

module vmt_fifo #(
  parameter int DEPTH = 4,
  parameter int W     = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* sv/vmt_front.sv */
`default_nettype none

module vmt_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  vmt_pkg::vmt_in_t              in_req,
  input  logic                          cfg_we,
  input  logic [vmt_pkg::IDX_W-1:0]     cfg_idx,
  input  logic [vmt_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                          mid_push,
  output vmt_pkg::vmt_mid_t             mid_data,
  input  logic                          mid_full
);
  import vmt_pkg::*;

  logic [CFG_W-1:0]          m_r [NREG];
  logic signed [31:0]        ent [4][4];
  logic signed [63:0]        prod_r [3][4];
  logic signed [63:0]        prod_nxt [3][4];
  logic                      op_a_r, va_r, vb_r, adv;
  vmt_mid_t                  mid_r, mid_nxt;
  vmt_sum_t                  sum [4];

  // Matrix registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= M_RESET;
    end else if (cfg_we) begin
      m_r[cfg_idx] <= cfg_wdata;
    end
  end

  // Unpack matrix entries
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        ent[r][c] = (c % 2 == 1) ? m_r[r * 2 + c / 2][63:32] : m_r[r * 2 + c / 2][31:0];
      end
    end
  end

  // Stall the whole front when the queue cannot take the oldest request
  assign adv      = !(vb_r && mid_full);
  assign in_full  = !adv;
  assign mid_push = adv && vb_r;
  assign mid_data = mid_r;

  // Form the three coordinate products per column
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      prod_nxt[0][c] = in_req.in_x * ent[0][c];
      prod_nxt[1][c] = in_req.in_y * ent[1][c];
      prod_nxt[2][c] = in_req.in_z * ent[2][c];
    end
  end

  // Sum columns, add translation for points, classify
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum[c] = SUM_W'(prod_r[0][c]) + SUM_W'(prod_r[1][c]) + SUM_W'(prod_r[2][c]);
      if (op_a_r == OP_POINT) begin
        sum[c] = sum[c] + (SUM_W'(ent[3][c]) <<< FRAC_W);
      end
    end
    mid_nxt.is_dir = (op_a_r == OP_DIR);
    mid_nxt.w_zero = (op_a_r == OP_POINT) && (sum[3] == '0);
    mid_nxt.sx     = sum[0];
    mid_nxt.sy     = sum[1];
    mid_nxt.sz     = sum[2];
    mid_nxt.sw     = sum[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_push;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      op_a_r <= in_req.op;
      mid_r  <= mid_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/vmt_back.sv */
`default_nettype none

module vmt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mid_empty,
  input  vmt_pkg::vmt_mid_t  mid_data,
  output logic               mid_pop,
  output logic               out_push,
  output vmt_pkg::vmt_out_t  out_data,
  input  logic               out_full
);
  import vmt_pkg::*;

  localparam int NSTG = QBITS;

  logic                 v_r    [NSTG+1];
  logic                 dir_r  [NSTG+1];
  logic                 wz_r   [NSTG+1];
  logic [MAG_W-1:0]     d_r    [NSTG+1];
  logic [NUM_W-1:0]     p_r    [NSTG+1][NLANE];
  logic [QBITS-1:0]     q_r    [NSTG+1][NLANE];
  logic                 neg_r  [NSTG+1][NLANE];
  logic                 ovf_r  [NSTG+1][NLANE];
  logic [COORD_W-1:0]   dres_r [NSTG+1][NLANE];

  logic [NUM_W-1:0]     p_nxt  [1:NSTG][NLANE];
  logic [QBITS-1:0]     q_nxt  [1:NSTG][NLANE];
  logic [NUM_W-1:0]     p0     [NLANE];
  logic                 neg0   [NLANE];
  logic                 ovf0   [NLANE];
  logic [COORD_W-1:0]   dres0  [NLANE];
  logic [MAG_W-1:0]     dmag;
  logic [COORD_W-1:0]   res    [NLANE];
  logic                 adv;

  assign adv      = !(v_r[NSTG] && out_full);
  assign mid_pop  = adv && !mid_empty;
  assign out_push = adv && v_r[NSTG];

  // Take magnitudes and signs, check quotient range, round directions down and saturate
  always_comb begin
    vmt_sum_t         s [NLANE];
    logic [SUM_W-1:0] a;
    logic [MAG_W-1:0] mag;
    vmt_sum_t         t;
    s[0] = mid_data.sx;
    s[1] = mid_data.sy;
    s[2] = mid_data.sz;
    a    = mid_data.sw[SUM_W-1] ? -mid_data.sw : mid_data.sw;
    dmag = a[MAG_W-1:0];
    for (int l = 0; l < NLANE; l++) begin
      a           = s[l][SUM_W-1] ? -s[l] : s[l];
      mag         = a[MAG_W-1:0];
      p0[l]       = {mag, {FRAC_W{1'b0}}};
      neg0[l]     = s[l][SUM_W-1] ^ mid_data.sw[SUM_W-1];
      ovf0[l]     = {{(REM_W-NUM_W){1'b0}}, p0[l]} >= {dmag, {QBITS{1'b0}}};
      t           = s[l] >>> FRAC_W;
      if (t > SUM_W'(signed'(SAT_MAX))) begin
        dres0[l] = SAT_MAX;
      end else if (t < SUM_W'(signed'(SAT_MIN))) begin
        dres0[l] = SAT_MIN;
      end else begin
        dres0[l] = t[COORD_W-1:0];
      end
    end
  end

  // One quotient bit per stage, most significant first
  always_comb begin
    logic [REM_W-1:0] pe, dsh;
    for (int s = 1; s <= NSTG; s++) begin
      dsh = {{QBITS{1'b0}}, d_r[s-1]} << (NSTG - s);
      for (int l = 0; l < NLANE; l++) begin
        pe          = {{(REM_W-NUM_W){1'b0}}, p_r[s-1][l]};
        q_nxt[s][l] = q_r[s-1][l];
        if (pe >= dsh) begin
          pe                      = pe - dsh;
          q_nxt[s][l][NSTG - s]   = 1'b1;
        end
        p_nxt[s][l] = pe[NUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= NSTG; s++) begin
        v_r[s] <= 1'b0;
      end
    end else if (adv) begin
      v_r[0] <= !mid_empty;
      for (int s = 1; s <= NSTG; s++) begin
        v_r[s] <= v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dir_r[0] <= mid_data.is_dir;
      wz_r[0]  <= mid_data.w_zero;
      d_r[0]   <= dmag;
      for (int l = 0; l < NLANE; l++) begin
        p_r[0][l]    <= p0[l];
        q_r[0][l]    <= '0;
        neg_r[0][l]  <= neg0[l];
        ovf_r[0][l]  <= ovf0[l];
        dres_r[0][l] <= dres0[l];
      end
      for (int s = 1; s <= NSTG; s++) begin
        dir_r[s] <= dir_r[s-1];
        wz_r[s]  <= wz_r[s-1];
        d_r[s]   <= d_r[s-1];
        for (int l = 0; l < NLANE; l++) begin
          p_r[s][l]    <= p_nxt[s][l];
          q_r[s][l]    <= q_nxt[s][l];
          neg_r[s][l]  <= neg_r[s-1][l];
          ovf_r[s][l]  <= ovf_r[s-1][l];
          dres_r[s][l] <= dres_r[s-1][l];
        end
      end
    end
  end

  // Zero w_zero results, pass directions through, else apply sign and saturate
  always_comb begin
    logic [QBITS-1:0] q;
    for (int l = 0; l < NLANE; l++) begin
      q = q_r[NSTG][l];
      priority if (wz_r[NSTG]) begin
        res[l] = '0;
      end else if (dir_r[NSTG]) begin
        res[l] = dres_r[NSTG][l];
      end else if (ovf_r[NSTG][l]) begin
        res[l] = neg_r[NSTG][l] ? SAT_MIN : SAT_MAX;
      end else if (neg_r[NSTG][l]) begin
        res[l] = (q >= SAT_MIN) ? SAT_MIN : -q;
      end else begin
        res[l] = (q > SAT_MAX) ? SAT_MAX : q;
      end
    end
  end

  assign out_data.out_x  = res[0];
  assign out_data.out_y  = res[1];
  assign out_data.out_z  = res[2];
  assign out_data.w_zero = wz_r[NSTG];

endmodule

`default_nettype wire

/* sv/vertex_matrix_transform.sv */
// Path from an accepted request to its result on the out_ ports: two multiply/sum
//   stages, the middle queue, range check, 32 divider stages, the output queue.
// Throughput: one request per cycle while in_full stays low; the 32-stage quotient pipeline
//   produces one bit per stage for three lanes at once.
// Reset (rst_n low, synchronous): queues and pipelines empty, matrix set to
//   the identity.
`default_nettype none

module vertex_matrix_transform #(
  parameter int QUEUE_DEPTH = 4,
  parameter int OUT_DEPTH   = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  vmt_pkg::vmt_in_t          in_req,
  output logic                      out_empty,
  input  logic                      out_pop,
  output vmt_pkg::vmt_out_t         out_rsp,
  input  logic                      cfg_we,
  input  logic [vmt_pkg::IDX_W-1:0] cfg_idx,
  input  logic [vmt_pkg::CFG_W-1:0] cfg_wdata
);
  import vmt_pkg::*;

  logic     mid_push, mid_full, mid_pop, mid_empty, out_push, out_full;
  vmt_mid_t mid_wdata, mid_rdata;
  vmt_out_t out_wdata;

  vmt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_req   (in_req),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .mid_push (mid_push),
    .mid_data (mid_wdata),
    .mid_full (mid_full)
  );

  vmt_fifo #(.DEPTH(QUEUE_DEPTH), .W($bits(vmt_mid_t))) u_mid_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (mid_push),
    .wdata(mid_wdata),
    .full (mid_full),
    .pop  (mid_pop),
    .rdata(mid_rdata),
    .empty(mid_empty)
  );

  vmt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .mid_empty(mid_empty),
    .mid_data (mid_rdata),
    .mid_pop  (mid_pop),
    .out_push (out_push),
    .out_data (out_wdata),
    .out_full (out_full)
  );

  vmt_fifo #(.DEPTH(OUT_DEPTH), .W($bits(vmt_out_t))) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (out_push),
    .wdata(out_wdata),
    .full (out_full),
    .pop  (out_pop),
    .rdata(out_rsp),
    .empty(out_empty)
  );

endmodule

`default_nettype wire

/* sv/vmt_check.sv */
`default_nettype none

module vmt_check (
  input logic              clk,
  input logic              rst_n,
  input logic              in_full,
  input logic              out_empty,
  input logic              out_pop,
  input vmt_pkg::vmt_out_t out_rsp
);

  // Reset drains everything and opens the input
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // A zero-w result carries zero coordinates
  a_wzero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_rsp.w_zero) |->
      (out_rsp.out_x == 0 && out_rsp.out_y == 0 && out_rsp.out_z == 0))
    else $error("w_zero result with nonzero coordinates");

  // A waiting result holds until popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_rsp)))
    else $error("waiting result changed");

endmodule

bind vertex_matrix_transform vmt_check u_vmt_check (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_full  (in_full),
  .out_empty(out_empty),
  .out_pop  (out_pop),
  .out_rsp  (out_rsp)
);

`default_nettype wire

/* test/tb_vertex_matrix_transform.sv */
`default_nettype none

module tb_vertex_matrix_transform;
  import vmt_pkg::*;

  localparam int LATENCY   = 36;
  localparam int WDOG_MAX  = 4000;
  localparam int N_RANDOM  = 800;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_push = 1'b0;
  logic     in_full;
  vmt_in_t  in_req = '0;
  logic     out_empty;
  logic     out_pop = 1'b0;
  vmt_out_t out_rsp;
  logic     cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  vertex_matrix_transform dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_req(in_req),
    .out_empty(out_empty), .out_pop(out_pop), .out_rsp(out_rsp),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the matrix registers
  logic [CFG_W-1:0] matrix [NREG];
  vmt_out_t xform_q[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  stim_done = 1'b0;
  bit  hold_rx = 1'b0;
  bit  hold_go = 1'b0;

  function automatic logic signed [127:0] mat_elem(int r, int c);
    logic [CFG_W-1:0] v;
    logic [31:0] h;
    v = matrix[r*2 + c/2];
    h = (c % 2) ? v[63:32] : v[31:0];
    return 128'(signed'(h));
  endfunction

  function automatic logic signed [127:0] col_sum(vmt_in_t rq, int c, bit point);
    logic signed [127:0] s;
    s = 128'(rq.in_x) * mat_elem(0, c) + 128'(rq.in_y) * mat_elem(1, c)
      + 128'(rq.in_z) * mat_elem(2, c);
    if (point) s = s + 128'sd65536 * mat_elem(3, c);
    return s;
  endfunction

  function automatic logic [31:0] sat32(logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF) return SAT_MAX;
    if (v < -128'sh8000_0000) return SAT_MIN;
    return v[31:0];
  endfunction

  function automatic vmt_out_t transform_vertex(vmt_in_t rq);
    vmt_out_t r;
    logic signed [127:0] w, s, q;
    logic [31:0] o [3];
    r = '0;
    if (rq.op == OP_DIR) begin
      // floor shift of each exact sum
      for (int c = 0; c < 3; c++) begin
        s = col_sum(rq, c, 1'b0);
        o[c] = sat32(s >>> 16);
      end
    end else begin
      w = col_sum(rq, 3, 1'b1);
      if (w == 0) begin
        r.w_zero = 1'b1;
        return r;
      end
      // truncating divide; sums fit well inside 128 bits after the 2^16 scale
      for (int c = 0; c < 3; c++) begin
        s = col_sum(rq, c, 1'b1) * 128'sd65536;
        q = s / w;
        o[c] = sat32(q);
      end
    end
    r.out_x = o[0];
    r.out_y = o[1];
    r.out_z = o[2];
    return r;
  endfunction

  task automatic write_reg(int idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= IDX_W'(idx);
    cfg_wdata <= val;
    matrix[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drop the request, wait until every expected result has drained, then settle
  task automatic drain();
    in_push <= 1'b0;
    while (xform_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_request(vmt_in_t rq);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_req <= rq;
    do @(posedge clk); while (in_full);
    xform_q.push_back(transform_vertex(rq));
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
      1: return $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
      2: return 32'(signed'($urandom_range(0, 512)) - 256);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rand_pair();
    return {rand_coord(), rand_coord()};
  endfunction

  // Directed table: op, x, y, z, check-against-table flag, expected
  typedef struct {
    logic     op;
    logic [31:0] x, y, z;
    bit       fixed;
    vmt_out_t exp;
  } dir_row_t;

  dir_row_t dir_tab [] = '{
    '{OP_POINT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1,
      '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0}},
    '{OP_DIR, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 1'b1,
      '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 1'b0}},
    '{OP_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0}},
    '{OP_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1,
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0}},
    '{OP_DIR, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1,
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0}},
    '{OP_POINT, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{OP_DIR, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 1'b0, '0}
  };

  // Second directed table run with w = z (column 3 = row 2 only): z = 0 hits w zero
  dir_row_t wz_tab [] = '{
    '{OP_POINT, 32'h0005_0000, 32'h0007_0000, 32'h0, 1'b1, '{32'h0, 32'h0, 32'h0, 1'b1}},
    '{OP_POINT, 32'h0004_0000, 32'h0002_0000, 32'h0002_0000, 1'b0, '0},
    '{OP_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0, '0},
    '{OP_POINT, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_DIR, 32'h0004_0000, 32'h0002_0000, 32'h0, 1'b0, '0}
  };

  task automatic run_table(dir_row_t tab []);
    vmt_in_t rq;
    foreach (tab[i]) begin
      rq.op = tab[i].op;
      rq.in_x = tab[i].x;
      rq.in_y = tab[i].y;
      rq.in_z = tab[i].z;
      send_request(rq);
      if (tab[i].fixed) xform_q[$] = tab[i].exp;
    end
  endtask

  task automatic run_random(int n);
    vmt_in_t rq;
    repeat (n) begin
      rq.op = 1'($urandom_range(0, 1));
      rq.in_x = rand_coord();
      rq.in_y = rand_coord();
      rq.in_z = rand_coord();
      send_request(rq);
    end
  endtask

  // Stimulus
  initial begin
    foreach (matrix[i]) matrix[i] = M_RESET[i];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    run_table(dir_tab);
    drain();
    // w taken from z alone: column 3 = (0, 0, 1, 0)
    write_reg(1, 64'h0);
    write_reg(3, 64'h0);
    write_reg(5, {32'h0001_0000, 32'h0001_0000});
    write_reg(7, 64'h0);
    run_table(wz_tab);
    drain();
    // Extreme matrix
    for (int i = 0; i < NREG; i++)
      write_reg(i, (i % 2) ? 64'h8000_0000_7FFF_FFFF : 64'h7FFF_FFFF_8000_0000);
    run_random(N_RANDOM / 8);
    drain();
    for (int i = 0; i < NREG; i++) write_reg(i, 64'hFFFF_FFFF_FFFF_FFFF);
    run_random(N_RANDOM / 8);
    drain();
    // Several random matrices, each with a random mix
    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < NREG; i++) write_reg(i, rand_pair());
      run_random(N_RANDOM / 8);
      drain();
    end
    // Near-identity with small translation and a nonzero w column
    for (int i = 0; i < NREG; i++) write_reg(i, M_RESET[i]);
    write_reg(6, {32'(signed'($urandom_range(0, 1 << 18)) - (1 << 17)),
                  32'(signed'($urandom_range(0, 1 << 18)) - (1 << 17))});
    write_reg(3, {32'h0000_1000, 32'h0});
    hold_go = 1'b1;
    run_random(N_RANDOM - 5 * (N_RANDOM / 8));
    in_push <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: one long hold-off during the last random run to fill the block
  initial begin
    wait (hold_go);
    repeat (40) @(posedge clk);
    hold_rx = 1'b1;
    repeat (300) @(posedge clk);
    hold_rx = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && !out_empty && out_pop) begin
      if (xform_q.size() == 0) begin
        $error("unexpected result %h", out_rsp);
        errors++;
      end else begin
        vmt_out_t e;
        e = xform_q.pop_front();
        if (out_rsp.out_x !== e.out_x) begin
          $error("out_x expected %h got %h", e.out_x, out_rsp.out_x); errors++;
        end
        if (out_rsp.out_y !== e.out_y) begin
          $error("out_y expected %h got %h", e.out_y, out_rsp.out_y); errors++;
        end
        if (out_rsp.out_z !== e.out_z) begin
          $error("out_z expected %h got %h", e.out_z, out_rsp.out_z); errors++;
        end
        if (out_rsp.w_zero !== e.w_zero) begin
          $error("w_zero expected %b got %b", e.w_zero, out_rsp.w_zero); errors++;
        end
      end
    end
  end

  // Pop driver: draw a wait per result, hold during the long stall
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0 || hold_rx) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_rx) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
    end
  end

  // Watchdog and end of run
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (xform_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && xform_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
